FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/lgre_pkg.sv
// shared types and constants of the led grid rotation engine
package lgre_pkg;

  localparam int STRIP_COUNT      = 8;
  localparam int PIXELS_PER_STRIP = 5;
  localparam int GEAR_STAGES      = 4;
  localparam int GEAR_W           = $clog2(STRIP_COUNT);

  localparam int OP_W    = 4;
  localparam int STRIP_W = 3;
  localparam int POS_W   = 3;
  localparam int COLOR_W = 8;
  localparam int PIXEL_W = 3 * COLOR_W;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 4'd0,
    OP_READ      = 4'd1,
    OP_RANK_FWD  = 4'd2,
    OP_RANK_REV  = 4'd3,
    OP_FILE_FWD  = 4'd4,
    OP_FILE_REV  = 4'd5,
    OP_SPIN_CW   = 4'd6,
    OP_SPIN_CCW  = 4'd7,
    OP_INTERLACE = 4'd8,
    OP_IMPLODE   = 4'd9,
    OP_EXPLODE   = 4'd10,
    OP_GEARS     = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    MV_HOLD       = 3'd0,
    MV_LOAD       = 3'd1,
    MV_NEXT_STRIP = 3'd2,
    MV_PREV_STRIP = 3'd3,
    MV_NEXT_POS   = 3'd4,
    MV_PREV_POS   = 3'd5
  } cell_move_e;

endpackage

FILE: design/lgre_pixel_cell.sv
// one grid cell holding a pixel, loaded from a neighbor or the write port
module lgre_pixel_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lgre_pkg::cell_move_e move_i,
  input  lgre_pkg::pixel_t    wr_pixel_i,
  input  lgre_pkg::pixel_t    next_strip_i,
  input  lgre_pkg::pixel_t    prev_strip_i,
  input  lgre_pkg::pixel_t    next_pos_i,
  input  lgre_pkg::pixel_t    prev_pos_i,
  output lgre_pkg::pixel_t    pixel_o
);

  lgre_pkg::pixel_t pixel_d, pixel_q;

  always_comb begin
    case (move_i)
      lgre_pkg::MV_HOLD:       pixel_d = pixel_q;
      lgre_pkg::MV_LOAD:       pixel_d = wr_pixel_i;
      lgre_pkg::MV_NEXT_STRIP: pixel_d = next_strip_i;
      lgre_pkg::MV_PREV_STRIP: pixel_d = prev_strip_i;
      lgre_pkg::MV_NEXT_POS:   pixel_d = next_pos_i;
      lgre_pkg::MV_PREV_POS:   pixel_d = prev_pos_i;
      default:                 pixel_d = pixel_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_q <= '0;
    end else begin
      pixel_q <= pixel_d;
    end
  end

  assign pixel_o = pixel_q;

endmodule

FILE: design/lgre_gear_cell.sv
// one gear counter modulo the strip count, passing a wrap carry onward
module lgre_gear_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  output logic carry_o
);

  logic [lgre_pkg::GEAR_W-1:0] count_d, count_q;

  always_comb begin
    if (count_q == lgre_pkg::GEAR_W'(lgre_pkg::STRIP_COUNT - 1)) begin
      count_d = '0;
    end else begin
      count_d = count_q + lgre_pkg::GEAR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (adv_i) begin
      count_q <= count_d;
    end
  end

  // carry when this advance lands on zero
  assign carry_o = adv_i && (count_d == '0);

endmodule

FILE: design/led_grid_rotation_engine_unit.sv
// led grid rotation engine top level: command decode, cell grid, gear chain, result register
// Holds an RGB grid of 8 strips by 5 positions in a mesh of pixel cells, each cell wired to
// its four ring neighbors, plus a chain of four gear counter cells. A command request on the
// slave stream (op in tuser) is applied to the whole grid in the clock edge that accepts it,
// and its result (pixel colour for a read, zero otherwise) sits in an output register until
// taken. One command per cycle: all cells update together, and the input is held
// off only while the output register is full and stalled. Reset clears all pixels to off.
module led_grid_rotation_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: strip_index[2:0], position_index[5:3], red_in[13:6], green_in[21:14],
  //        blue_in[29:22], zero[31:30]
  input  logic [31:0] s_axis_tdata_i,
  // tuser: op[3:0]
  input  logic [3:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic [23:0] m_axis_tdata_o
);

  localparam int S = lgre_pkg::STRIP_COUNT;
  localparam int P = lgre_pkg::PIXELS_PER_STRIP;
  localparam int G = lgre_pkg::GEAR_STAGES;

  logic                         cmd_acc;
  lgre_pkg::op_e                op;
  logic [lgre_pkg::STRIP_W-1:0] strip_idx;
  logic [lgre_pkg::POS_W-1:0]   pos_idx;
  lgre_pkg::pixel_t             wr_pixel;
  lgre_pkg::pixel_t             rd_pixel;

  lgre_pkg::pixel_t     grid   [S][P];
  lgre_pkg::cell_move_e move   [S][P];
  logic                 load_sel [S][P];
  logic [P-1:0]         rank_fwd, rank_rev;
  logic [S-1:0]         file_fwd, file_rev;

  logic [G-1:0] gear_adv;
  logic [G-1:0] gear_carry;
  logic [G:0]   gear_rank;

  logic             out_valid_q;
  lgre_pkg::pixel_t out_pixel_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign cmd_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign op        = lgre_pkg::op_e'(s_axis_tuser_i);
  assign strip_idx = s_axis_tdata_i[2:0];
  assign pos_idx   = s_axis_tdata_i[5:3];
  assign wr_pixel  = {s_axis_tdata_i[13:6], s_axis_tdata_i[21:14], s_axis_tdata_i[29:22]};

  // gear chain: stage 0 ticks on a gears request, each wrap ticks the next stage
  assign gear_adv[0] = cmd_acc && (op == lgre_pkg::OP_GEARS);
  assign gear_rank[0] = gear_adv[0];

  for (genvar k = 0; k < G; k++) begin : g_gear
    lgre_gear_cell u_gear (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (gear_adv[k]),
      .carry_o (gear_carry[k])
    );
    if (k + 1 < G) begin : g_next
      assign gear_adv[k+1] = gear_carry[k];
    end
    assign gear_rank[k+1] = gear_carry[k];
  end

  // per-rank and per-file move decode
  always_comb begin
    rank_fwd = '0;
    rank_rev = '0;
    file_fwd = '0;
    file_rev = '0;
    for (int p = 0; p < P; p++) begin
      case (op)
        lgre_pkg::OP_RANK_FWD:  rank_fwd[p] = (int'(pos_idx) == p);
        lgre_pkg::OP_RANK_REV:  rank_rev[p] = (int'(pos_idx) == p);
        lgre_pkg::OP_SPIN_CW:   rank_fwd[p] = 1'b1;
        lgre_pkg::OP_SPIN_CCW:  rank_rev[p] = 1'b1;
        lgre_pkg::OP_INTERLACE: begin
          rank_fwd[p] = (p % 2 == 1);
          rank_rev[p] = (p % 2 == 0);
        end
        lgre_pkg::OP_GEARS:     rank_fwd[p] = (p <= G) ? gear_rank[p] : 1'b0;
        default: ;
      endcase
    end
    for (int s = 0; s < S; s++) begin
      case (op)
        lgre_pkg::OP_FILE_FWD: file_fwd[s] = (int'(strip_idx) == s);
        lgre_pkg::OP_FILE_REV: file_rev[s] = (int'(strip_idx) == s);
        lgre_pkg::OP_IMPLODE:  file_fwd[s] = 1'b1;
        lgre_pkg::OP_EXPLODE:  file_rev[s] = 1'b1;
        default: ;
      endcase
    end
  end

  // cell moves and read select
  always_comb begin
    rd_pixel = '0;
    for (int s = 0; s < S; s++) begin
      for (int p = 0; p < P; p++) begin
        load_sel[s][p] = (op == lgre_pkg::OP_WRITE) && (int'(strip_idx) == s)
                         && (int'(pos_idx) == p);
        if (!cmd_acc) begin
          move[s][p] = lgre_pkg::MV_HOLD;
        end else if (load_sel[s][p]) begin
          move[s][p] = lgre_pkg::MV_LOAD;
        end else if (rank_fwd[p]) begin
          move[s][p] = lgre_pkg::MV_NEXT_STRIP;
        end else if (rank_rev[p]) begin
          move[s][p] = lgre_pkg::MV_PREV_STRIP;
        end else if (file_fwd[s]) begin
          move[s][p] = lgre_pkg::MV_NEXT_POS;
        end else if (file_rev[s]) begin
          move[s][p] = lgre_pkg::MV_PREV_POS;
        end else begin
          move[s][p] = lgre_pkg::MV_HOLD;
        end
        if ((op == lgre_pkg::OP_READ) && (int'(strip_idx) == s) && (int'(pos_idx) == p)) begin
          rd_pixel = grid[s][p];
        end
      end
    end
  end

  for (genvar s = 0; s < S; s++) begin : g_strip
    for (genvar p = 0; p < P; p++) begin : g_pos
      localparam int SN = (s + 1) % S;
      localparam int SP = (s + S - 1) % S;
      localparam int PN = (p + 1) % P;
      localparam int PP = (p + P - 1) % P;
      lgre_pixel_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .move_i       (move[s][p]),
        .wr_pixel_i   (wr_pixel),
        .next_strip_i (grid[SN][p]),
        .prev_strip_i (grid[SP][p]),
        .next_pos_i   (grid[s][PN]),
        .prev_pos_i   (grid[s][PP]),
        .pixel_o      (grid[s][p])
      );
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      out_pixel_q <= rd_pixel;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_pixel_q[7:0], out_pixel_q[15:8], out_pixel_q[23:16]};

endmodule

FILE: design/lgre_checker.sv
// port-level checker for the led grid rotation engine, bound to the top level
`include "assert_macros.svh"

module lgre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i,
  input logic [3:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  logic        s_acc;
  logic        non_read;
  logic        wr_acc;
  logic        rd_hit;
  logic [5:0]  addr;
  logic [23:0] color_in;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign non_read = s_axis_tuser_i != lgre_pkg::OP_READ;
  assign addr     = s_axis_tdata_i[5:0];
  assign color_in = s_axis_tdata_i[29:6];
  assign wr_acc   = s_acc && (s_axis_tuser_i == lgre_pkg::OP_WRITE);
  assign rd_hit   = s_acc && (s_axis_tuser_i == lgre_pkg::OP_READ)
                    && (int'(s_axis_tdata_i[2:0]) < lgre_pkg::STRIP_COUNT)
                    && (int'(s_axis_tdata_i[5:3]) < lgre_pkg::PIXELS_PER_STRIP);

  `ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid_o, s_axis_tready_o)
  `ASSERT_NEXT(a_non_read_zero, clk_i, rst_ni, s_acc && non_read, m_axis_tvalid_o && (m_axis_tdata_o == '0))
  // read of the pixel written by the request just before
  `ASSERT_NEXT(a_read_after_write, clk_i, rst_ni, rd_hit && $past(wr_acc) && (addr == $past(addr)),
               m_axis_tdata_o == $past(color_in, 2))
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o))

endmodule

bind led_grid_rotation_engine_unit lgre_checker u_lgre_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
